[rtl/rpf_pkg.sv]
// Package for the raw pulse packet framer: widths, register indexes, shared types.
`timescale 1ns / 1ps
`default_nettype none

package rpf_pkg;

   localparam int DURATION_W     = 16;
   localparam int MIN_PULSES_W   = 7;
   localparam int PULSE_INDEX_W  = 6;
   localparam int CSR_INDEX_W    = 8;
   localparam int CSR_DATA_W     = 16;

   localparam int MAX_PULSES_DEFAULT = 64;

   localparam logic [CSR_DATA_W-1:0]   NOISE_RESET = 16'd50;
   localparam logic [CSR_DATA_W-1:0]   GAP_RESET   = 16'd10000;
   localparam logic [MIN_PULSES_W-1:0] MIN_RESET   = 7'd16;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NOISE_THRESHOLD   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_THRESHOLD     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PACKET_PULSES = 8'd2;

   // Per-item decision from the classifier
   typedef struct packed {
      logic append;   // store the magnitude at the current fill position
      logic emit;     // replay the buffer as a packet
   } pulse_decision_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_LOAD = 3'b100
   } framer_state_type;

endpackage

`default_nettype wire

[rtl/rpf_pulse_class.sv]
// Pulse classifier: magnitude, threshold tests and buffer fill decision for one item.
`timescale 1ns / 1ps
`default_nettype none

module rpf_pulse_class #(
   parameter int MAX_PULSES = rpf_pkg::MAX_PULSES_DEFAULT,
   parameter int CW = $clog2(MAX_PULSES + 1),
   parameter int AW = $clog2(MAX_PULSES)
) (
   input  wire logic signed [rpf_pkg::DURATION_W-1:0]  raw_duration,
   input  wire logic                                   end_of_capture,
   input  wire logic [rpf_pkg::DURATION_W-1:0]         noise_threshold,
   input  wire logic [rpf_pkg::DURATION_W-1:0]         gap_threshold,
   input  wire logic [rpf_pkg::MIN_PULSES_W-1:0]       min_packet_pulses,
   input  wire logic [CW-1:0]                          fill_count,
   output      logic [rpf_pkg::DURATION_W-1:0]         duration,
   output      rpf_pkg::pulse_decision_type            decision,
   output      logic [CW-1:0]                          next_count,
   output      logic [AW-1:0]                          emit_last
);
   import rpf_pkg::*;

   logic          is_noise;
   logic          is_gap;
   logic          room;
   logic          overflow;
   logic [CW-1:0] count_app;
   logic [CW-1:0] judged;
   logic          meets_min;

   // -32768 wraps to 0x8000, which is its magnitude read unsigned
   assign duration = raw_duration[DURATION_W-1] ? DURATION_W'(-raw_duration)
                                                : DURATION_W'(raw_duration);

   assign is_noise = duration < noise_threshold;
   assign is_gap   = !is_noise && (duration >= gap_threshold);
   assign room     = fill_count < CW'(MAX_PULSES);
   assign overflow = !is_noise && !is_gap && !room;

   assign decision.append = !is_noise && room;
   assign count_app       = decision.append ? fill_count + CW'(1) : fill_count;

   // Pulses held once this item is dealt with, as seen by the packet test
   assign judged    = (is_noise || overflow) ? '0 : count_app;
   assign meets_min = (judged != '0) && (MIN_PULSES_W'(judged) >= min_packet_pulses);

   assign decision.emit = (is_gap || end_of_capture) && meets_min;
   assign emit_last     = AW'(judged - CW'(1));

   assign next_count = (is_noise || is_gap || overflow || end_of_capture) ? '0 : count_app;

endmodule

`default_nettype wire

[rtl/raw_pulse_packet_framer_unit.sv]
// Raw pulse packet framer top level: pulse buffer memory, replay sequencer, registers.
`timescale 1ns / 1ps
`default_nettype none

// Chan  Dir  Handshake    Fields
// req   in   valid/stall  req_raw_duration[15:0] (signed), req_end_of_capture
// rsp   out  valid/stall  rsp_pulse_duration[15:0], rsp_pulse_index[5:0], rsp_last_of_packet
// csr   in   csr_write    csr_index[7:0], csr_data[15:0]
//
// A non-emitting item leaves the sequencer idle. An item that emits a packet holds req off
// while the single read port replays it, through a read and a load state per pulse, and for
// as long as the output register waits on rsp_stall. The next item is taken
// while the final transfer of a packet still waits in the output register.
// Synchronous reset clears the count and sequencer and loads the configuration defaults;
// the buffer memory is not cleared, as only entries below the fill count are read.

module raw_pulse_packet_framer_unit #(
   parameter int MAX_PULSES = rpf_pkg::MAX_PULSES_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // input channel
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic signed [rpf_pkg::DURATION_W-1:0]  req_raw_duration,
   input  wire logic                                   req_end_of_capture,
   // result channel
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic [rpf_pkg::DURATION_W-1:0]         rsp_pulse_duration,
   output      logic [rpf_pkg::PULSE_INDEX_W-1:0]      rsp_pulse_index,
   output      logic                                   rsp_last_of_packet,
   // configuration
   input  wire logic                                   csr_write,
   input  wire logic [rpf_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [rpf_pkg::CSR_DATA_W-1:0]         csr_data
);
   import rpf_pkg::*;

   localparam int CW = $clog2(MAX_PULSES + 1);   // fill count, holds MAX_PULSES
   localparam int AW = $clog2(MAX_PULSES);       // buffer address

   // Configuration registers
   logic [DURATION_W-1:0]   noise_ff, noise_in;
   logic [DURATION_W-1:0]   gap_ff, gap_in;
   logic [MIN_PULSES_W-1:0] min_ff, min_in;

   // Control
   framer_state_type state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;      // pulse being replayed
   logic [AW-1:0]    last_ptr_ff, last_ptr_in;  // index of final pulse of packet
   logic             rsp_valid_ff, rsp_valid_in;

   // Result payload
   logic [DURATION_W-1:0]    rsp_dur_ff, rsp_dur_in;
   logic [PULSE_INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Buffer memory, one write and one registered read port
   logic [DURATION_W-1:0] pulse_mem [MAX_PULSES];
   logic [DURATION_W-1:0] rd_data_ff;

   logic               req_xfer;
   logic               load_out;
   logic               at_last;
   logic [DURATION_W-1:0] duration;
   pulse_decision_type decision;
   logic [CW-1:0]      next_count;
   logic [AW-1:0]      emit_last;

   rpf_pulse_class #(
      .MAX_PULSES (MAX_PULSES),
      .CW         (CW),
      .AW         (AW)
   ) u_class (
      .raw_duration      (req_raw_duration),
      .end_of_capture    (req_end_of_capture),
      .noise_threshold   (noise_ff),
      .gap_threshold     (gap_ff),
      .min_packet_pulses (min_ff),
      .fill_count        (count_ff),
      .duration          (duration),
      .decision          (decision),
      .next_count        (next_count),
      .emit_last         (emit_last)
   );

   // Items are taken only while the sequencer is idle
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   // Output register free, or its transfer completes this cycle
   assign load_out = (state_ff == ST_LOAD) && (!rsp_valid_ff || !rsp_stall);
   assign at_last  = (rd_ptr_ff == last_ptr_ff);

   always_comb begin
      noise_in = noise_ff;
      gap_in   = gap_ff;
      min_in   = min_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_NOISE_THRESHOLD:   noise_in = csr_data;
            CSR_GAP_THRESHOLD:     gap_in   = csr_data;
            CSR_MIN_PACKET_PULSES: min_in   = csr_data[MIN_PULSES_W-1:0];
            default: ;             // unmapped index, dropped
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      last_ptr_in = last_ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               count_in = next_count;
               if (decision.emit) begin
                  rd_ptr_in   = '0;
                  last_ptr_in = emit_last;
                  state_in    = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (load_out) begin
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_ptr_in = rd_ptr_ff + AW'(1);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_dur_in   = rsp_dur_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_dur_in   = rd_data_ff;
         rsp_idx_in   = PULSE_INDEX_W'(rd_ptr_ff);
         rsp_last_in  = at_last;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff     <= NOISE_RESET;
         gap_ff       <= GAP_RESET;
         min_ff       <= MIN_RESET;
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         noise_ff     <= noise_in;
         gap_ff       <= gap_in;
         min_ff       <= min_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      last_ptr_ff <= last_ptr_in;
      rsp_dur_ff  <= rsp_dur_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Write at the fill position; replay reads start in the cycle after the write
   // that ends the packet, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (req_xfer && decision.append) begin
         pulse_mem[count_ff[AW-1:0]] <= duration;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_data_ff <= pulse_mem[rd_ptr_ff];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pulse_duration = rsp_dur_ff;
   assign rsp_pulse_index    = rsp_idx_ff;
   assign rsp_last_of_packet = rsp_last_ff;

endmodule

`default_nettype wire
